[rtl/core/ftdc_pkg.sv]
// ----------------------------------------------------------------------------
// ftdc_pkg: shared types and constants
// Item layouts, configuration set, defrost phase encoding and setpoint table
// for the fridge thermostat and defrost controller.
// ----------------------------------------------------------------------------
package ftdc_pkg;

  localparam int unsigned TEMP_W  = 11;
  localparam int unsigned OFFS_W  = 9;
  localparam int unsigned TIMER_W = 16;
  localparam int unsigned CMP_W   = 12;

  localparam logic [TIMER_W-1:0] SHORT_LOCKOUT_SECONDS = 16'd5;
  localparam logic [TIMER_W-1:0] SUPERFREEZE_MINUTES   = 16'd240;
  localparam logic [TIMER_W-1:0] RUN_MINUTES_MAX       = 16'hFFFF;
  localparam logic [2:0]         EIGHTHS_LAST          = 3'd7;
  localparam logic [5:0]         SECONDS_LAST          = 6'd59;

  typedef enum logic [2:0] {
    FUNC_INIT    = 3'd0,
    FUNC_TICK    = 3'd1,
    FUNC_CONTROL = 3'd2,
    FUNC_DEFROST = 3'd3,
    FUNC_START   = 3'd4
  } func_e;

  typedef enum logic [6:0] {
    PH_IDLE      = 7'b0000001,
    PH_WAIT_COLD = 7'b0000010,
    PH_COMPR_OFF = 7'b0000100,
    PH_HEAT_ON   = 7'b0001000,
    PH_HEATING   = 7'b0010000,
    PH_HEAT_OFF  = 7'b0100000,
    PH_RESTART   = 7'b1000000
  } phase_e;

  typedef enum logic [2:0] {
    REG_ON_OFFSET      = 3'd0,
    REG_OFF_OFFSET     = 3'd1,
    REG_EVA_START_TEMP = 3'd2,
    REG_EVA_STOP_TEMP  = 3'd3,
    REG_LOCKOUT_SEC    = 3'd4,
    REG_HEATER_MAX_SEC = 3'd5,
    REG_PASSIVE_SEC    = 3'd6,
    REG_INTERVAL_MIN   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [OFFS_W-1:0]  on_offset;
    logic signed [OFFS_W-1:0]  off_offset;
    logic signed [TEMP_W-1:0]  eva_defrost_start_temp;
    logic signed [TEMP_W-1:0]  eva_defrost_stop_temp;
    logic [TIMER_W-1:0]        compressor_lockout_seconds;
    logic [TIMER_W-1:0]        heater_max_seconds;
    logic [TIMER_W-1:0]        passive_defrost_seconds;
    logic [TIMER_W-1:0]        defrost_interval_minutes;
  } cfg_t;

  typedef struct packed {
    func_e                     func;
    logic signed [TEMP_W-1:0]  cabinet_temp;
    logic signed [TEMP_W-1:0]  evaporator_temp;
    logic [3:0]                setpoint_index;
    logic                      eva_overheat_error;
    logic                      eva_sensor_error;
    logic                      cabinet_sensor_error;
    logic                      superfreeze_set;
    logic                      defrost_on_start;
  } item_t;

  typedef struct packed {
    logic       compressor_on;
    logic       heater_on;
    logic [2:0] defrost_phase;
    logic       superfreeze_active;
    logic       defrost_flag_clear;
  } result_t;

  // setpoints -16 to -24 degrees in tenths, indices past the table clamp
  function automatic logic signed [CMP_W-1:0] setpoint_tenths(input logic [3:0] idx);
    logic signed [CMP_W-1:0] sp;
    case (idx)
      4'd0:    sp = -12'sd160;
      4'd1:    sp = -12'sd170;
      4'd2:    sp = -12'sd180;
      4'd3:    sp = -12'sd190;
      4'd4:    sp = -12'sd200;
      4'd5:    sp = -12'sd210;
      4'd6:    sp = -12'sd220;
      4'd7:    sp = -12'sd230;
      default: sp = -12'sd240;
    endcase
    return sp;
  endfunction

  function automatic logic [2:0] phase_code(input phase_e ph);
    logic [2:0] code;
    case (ph)
      PH_IDLE:      code = 3'd0;
      PH_WAIT_COLD: code = 3'd1;
      PH_COMPR_OFF: code = 3'd2;
      PH_HEAT_ON:   code = 3'd3;
      PH_HEATING:   code = 3'd4;
      PH_HEAT_OFF:  code = 3'd5;
      PH_RESTART:   code = 3'd6;
      default:      code = 3'd0;
    endcase
    return code;
  endfunction

endpackage

[rtl/core/ftdc_regs.sv]
// ----------------------------------------------------------------------------
// ftdc_regs: configuration register file
// APB-style write/read access to the eight thresholds and timer settings.
// ----------------------------------------------------------------------------
module ftdc_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output ftdc_pkg::cfg_t    cfg_o
);

  ftdc_pkg::cfg_t     cfg_q;
  ftdc_pkg::reg_idx_e idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign idx    = ftdc_pkg::reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.on_offset                  <= 9'sd20;
      cfg_q.off_offset                 <= -9'sd20;
      cfg_q.eva_defrost_start_temp     <= -11'sd200;
      cfg_q.eva_defrost_stop_temp      <= 11'sd100;
      cfg_q.compressor_lockout_seconds <= 16'd300;
      cfg_q.heater_max_seconds         <= 16'd2400;
      cfg_q.passive_defrost_seconds    <= 16'd600;
      cfg_q.defrost_interval_minutes   <= 16'd480;
    end else if (wr_en) begin
      case (idx)
        ftdc_pkg::REG_ON_OFFSET:      cfg_q.on_offset <= pwdata[8:0];
        ftdc_pkg::REG_OFF_OFFSET:     cfg_q.off_offset <= pwdata[8:0];
        ftdc_pkg::REG_EVA_START_TEMP: cfg_q.eva_defrost_start_temp <= pwdata[10:0];
        ftdc_pkg::REG_EVA_STOP_TEMP:  cfg_q.eva_defrost_stop_temp <= pwdata[10:0];
        ftdc_pkg::REG_LOCKOUT_SEC:    cfg_q.compressor_lockout_seconds <= pwdata[15:0];
        ftdc_pkg::REG_HEATER_MAX_SEC: cfg_q.heater_max_seconds <= pwdata[15:0];
        ftdc_pkg::REG_PASSIVE_SEC:    cfg_q.passive_defrost_seconds <= pwdata[15:0];
        ftdc_pkg::REG_INTERVAL_MIN:   cfg_q.defrost_interval_minutes <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      ftdc_pkg::REG_ON_OFFSET:      prdata = {23'd0, cfg_q.on_offset};
      ftdc_pkg::REG_OFF_OFFSET:     prdata = {23'd0, cfg_q.off_offset};
      ftdc_pkg::REG_EVA_START_TEMP: prdata = {21'd0, cfg_q.eva_defrost_start_temp};
      ftdc_pkg::REG_EVA_STOP_TEMP:  prdata = {21'd0, cfg_q.eva_defrost_stop_temp};
      ftdc_pkg::REG_LOCKOUT_SEC:    prdata = {16'd0, cfg_q.compressor_lockout_seconds};
      ftdc_pkg::REG_HEATER_MAX_SEC: prdata = {16'd0, cfg_q.heater_max_seconds};
      ftdc_pkg::REG_PASSIVE_SEC:    prdata = {16'd0, cfg_q.passive_defrost_seconds};
      ftdc_pkg::REG_INTERVAL_MIN:   prdata = {16'd0, cfg_q.defrost_interval_minutes};
      default:                      prdata = 32'd0;
    endcase
  end

endmodule

[rtl/core/ftdc_ctrl.sv]
// ----------------------------------------------------------------------------
// ftdc_ctrl: thermostat state and next-state logic
// Holds prescaler, timers, compressor/heater state and the defrost sequencer;
// computes the state after one item and the result it reports.
// ----------------------------------------------------------------------------
module ftdc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  ftdc_pkg::item_t     item_i,
  input  ftdc_pkg::cfg_t      cfg_i,
  output ftdc_pkg::result_t   res_o
);

  logic                  tick_q, tick_d;
  logic [2:0]            eighth_q, eighth_d;
  logic [5:0]            msec_q, msec_d;
  logic                  comp_q, comp_d;
  logic                  heat_q, heat_d;
  ftdc_pkg::phase_e      phase_q, phase_d;
  logic [15:0]           lockout_q, lockout_d;
  logic [15:0]           hcount_q, hcount_d;
  logic [15:0]           run_q, run_d;
  logic                  sf_q, sf_d;
  logic [15:0]           sfleft_q, sfleft_d;
  logic                  pulse;

  logic signed [11:0]    sp, on_t, off_t, cab, eva;
  logic                  fault;
  logic [15:0]           sf_dec;

  assign sp    = ftdc_pkg::setpoint_tenths(item_i.setpoint_index);
  assign on_t  = sp + 12'(cfg_i.on_offset);
  assign off_t = sp + 12'(cfg_i.off_offset);
  assign cab   = 12'(item_i.cabinet_temp);
  assign eva   = 12'(item_i.evaporator_temp);
  assign fault = item_i.eva_overheat_error | item_i.eva_sensor_error
               | item_i.cabinet_sensor_error;
  assign sf_dec = sfleft_q - 16'd1;

  always_comb begin
    tick_d    = tick_q;
    eighth_d  = eighth_q;
    msec_d    = msec_q;
    comp_d    = comp_q;
    heat_d    = heat_q;
    phase_d   = phase_q;
    lockout_d = lockout_q;
    hcount_d  = hcount_q;
    run_d     = run_q;
    sfleft_d  = sfleft_q;
    sf_d      = sf_q | item_i.superfreeze_set;
    pulse     = 1'b0;

    case (item_i.func)
      ftdc_pkg::FUNC_INIT: begin
        lockout_d = (cab >= on_t) ? ftdc_pkg::SHORT_LOCKOUT_SECONDS
                                  : cfg_i.compressor_lockout_seconds;
        comp_d   = 1'b0;
        tick_d   = 1'b0;
        heat_d   = 1'b0;
        run_d    = 16'd0;
        sfleft_d = ftdc_pkg::SUPERFREEZE_MINUTES;
        sf_d     = 1'b0;
        phase_d  = item_i.defrost_on_start ? ftdc_pkg::PH_WAIT_COLD : ftdc_pkg::PH_IDLE;
      end
      ftdc_pkg::FUNC_TICK: begin
        tick_d = 1'b1;
      end
      ftdc_pkg::FUNC_CONTROL: begin
        // prescaler: eight ticks make a second, sixty seconds a minute
        if (tick_q) begin
          tick_d = 1'b0;
          if (eighth_q == ftdc_pkg::EIGHTHS_LAST) begin
            eighth_d = 3'd0;
            if (lockout_q != 16'd0) lockout_d = lockout_q - 16'd1;
            if (hcount_q != 16'd0) hcount_d = hcount_q - 16'd1;
            if (msec_q == ftdc_pkg::SECONDS_LAST) begin
              msec_d = 6'd0;
              if (sf_d) begin
                if (sf_dec == 16'd0) begin
                  sf_d     = 1'b0;
                  sfleft_d = ftdc_pkg::SUPERFREEZE_MINUTES;
                end else begin
                  sfleft_d = sf_dec;
                end
              end
              if (comp_q && phase_q == ftdc_pkg::PH_IDLE &&
                  run_q != ftdc_pkg::RUN_MINUTES_MAX) begin
                run_d = run_q + 16'd1;
              end
              if (phase_q == ftdc_pkg::PH_IDLE && run_d >= cfg_i.defrost_interval_minutes) begin
                phase_d = ftdc_pkg::PH_WAIT_COLD;
              end
            end else begin
              msec_d = msec_q + 6'd1;
            end
          end else begin
            eighth_d = eighth_q + 3'd1;
          end
        end
        // hysteresis with lockout, held off on a fault or while defrost owns the compressor
        if (fault || (phase_d != ftdc_pkg::PH_IDLE && phase_d != ftdc_pkg::PH_WAIT_COLD)) begin
          if (comp_q) begin
            comp_d    = 1'b0;
            lockout_d = cfg_i.compressor_lockout_seconds;
          end
        end else if (!comp_q) begin
          if ((sf_d || cab >= on_t) && lockout_d == 16'd0) comp_d = 1'b1;
        end else if (!sf_d && cab <= off_t) begin
          comp_d    = 1'b0;
          lockout_d = cfg_i.compressor_lockout_seconds;
        end
      end
      ftdc_pkg::FUNC_DEFROST: begin
        if (fault) begin
          heat_d = 1'b0;
        end else begin
          case (phase_q)
            ftdc_pkg::PH_IDLE: begin
              heat_d = 1'b0;
            end
            ftdc_pkg::PH_WAIT_COLD: begin
              if (eva <= 12'(cfg_i.eva_defrost_start_temp)) phase_d = ftdc_pkg::PH_COMPR_OFF;
              heat_d = 1'b0;
            end
            ftdc_pkg::PH_COMPR_OFF: begin
              comp_d    = 1'b0;
              lockout_d = cfg_i.compressor_lockout_seconds;
              phase_d   = ftdc_pkg::PH_HEAT_ON;
            end
            ftdc_pkg::PH_HEAT_ON: begin
              heat_d   = 1'b1;
              hcount_d = cfg_i.heater_max_seconds;
              phase_d  = ftdc_pkg::PH_HEATING;
            end
            ftdc_pkg::PH_HEATING: begin
              heat_d = 1'b1;
              if (eva >= 12'(cfg_i.eva_defrost_stop_temp) || hcount_q == 16'd0) begin
                phase_d = ftdc_pkg::PH_HEAT_OFF;
              end
            end
            ftdc_pkg::PH_HEAT_OFF: begin
              heat_d = 1'b0;
              if (lockout_q < cfg_i.passive_defrost_seconds) begin
                lockout_d = cfg_i.passive_defrost_seconds;
              end
              phase_d = ftdc_pkg::PH_RESTART;
            end
            ftdc_pkg::PH_RESTART: begin
              if (lockout_q == 16'd0) begin
                if (cab > off_t) comp_d = 1'b1;
                heat_d  = 1'b0;
                phase_d = ftdc_pkg::PH_IDLE;
                run_d   = 16'd0;
                pulse   = item_i.defrost_on_start;
              end
            end
            default: ;
          endcase
        end
      end
      ftdc_pkg::FUNC_START: begin
        phase_d = ftdc_pkg::PH_WAIT_COLD;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q    <= 1'b0;
      eighth_q  <= 3'd0;
      msec_q    <= 6'd0;
      comp_q    <= 1'b0;
      heat_q    <= 1'b0;
      phase_q   <= ftdc_pkg::PH_IDLE;
      lockout_q <= 16'd0;
      hcount_q  <= 16'd0;
      run_q     <= 16'd0;
      sf_q      <= 1'b0;
      sfleft_q  <= ftdc_pkg::SUPERFREEZE_MINUTES;
    end else if (step_i) begin
      tick_q    <= tick_d;
      eighth_q  <= eighth_d;
      msec_q    <= msec_d;
      comp_q    <= comp_d;
      heat_q    <= heat_d;
      phase_q   <= phase_d;
      lockout_q <= lockout_d;
      hcount_q  <= hcount_d;
      run_q     <= run_d;
      sf_q      <= sf_d;
      sfleft_q  <= sfleft_d;
    end
  end

  assign res_o.compressor_on      = comp_d;
  assign res_o.heater_on          = heat_d;
  assign res_o.defrost_phase      = ftdc_pkg::phase_code(phase_d);
  assign res_o.superfreeze_active = sf_d;
  assign res_o.defrost_flag_clear = pulse;

endmodule

[rtl/core/fridge_thermostat_defrost_controller_core.sv]
// ----------------------------------------------------------------------------
// fridge_thermostat_defrost_controller_core: refrigerator thermostat top level
// Input register, controller state update and result register, plus the
// configuration register file.
// ----------------------------------------------------------------------------
// Takes one item per clock when the result side keeps up; each item yields
// exactly one result: it is held in the input register, then the state update
// and the result capture happen together when it advances. The rate is set by
// the single state update per cycle in the controller. The user must write the
// configuration registers only while no item is in flight; it is not enforced.
module fridge_thermostat_defrost_controller_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [10:0] cabinet_temp, [21:11] evaporator_temp, [25:22] setpoint_index,
  // [26] eva_overheat_error, [27] eva_sensor_error, [28] cabinet_sensor_error,
  // [29] superfreeze_set, [30] defrost_on_start, [31] ignored
  input  logic [31:0] s_axis_tdata_i,
  // [2:0] func
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] compressor_on, [1] heater_on, [4:2] defrost_phase,
  // [5] superfreeze_active, [6] defrost_flag_clear, [7] zero
  output logic [7:0]  m_axis_tdata_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ftdc_pkg::cfg_t     cfg;
  ftdc_pkg::item_t    item_q;
  ftdc_pkg::result_t  res;
  ftdc_pkg::result_t  res_q;
  logic               in_valid_q;
  logic               out_valid_q;
  logic               advance;
  logic               in_take;

  ftdc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign advance         = in_valid_q & (~out_valid_q | m_axis_tready_i);
  assign s_axis_tready_o = ~in_valid_q | advance;
  assign in_take         = s_axis_tvalid_i & s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_take | (in_valid_q & ~advance);
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.func                 <= ftdc_pkg::func_e'(s_axis_tuser_i);
      item_q.cabinet_temp         <= s_axis_tdata_i[10:0];
      item_q.evaporator_temp      <= s_axis_tdata_i[21:11];
      item_q.setpoint_index       <= s_axis_tdata_i[25:22];
      item_q.eva_overheat_error   <= s_axis_tdata_i[26];
      item_q.eva_sensor_error     <= s_axis_tdata_i[27];
      item_q.cabinet_sensor_error <= s_axis_tdata_i[28];
      item_q.superfreeze_set      <= s_axis_tdata_i[29];
      item_q.defrost_on_start     <= s_axis_tdata_i[30];
    end
    if (advance) begin
      res_q <= res;
    end
  end

  ftdc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, res_q.defrost_flag_clear, res_q.superfreeze_active,
                            res_q.defrost_phase, res_q.heater_on, res_q.compressor_on};

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: fridge thermostat and defrost controller
// Drives control items on the input stream and predicts every result from a
// cycle-free model of the prescaler, compressor lockout, super-freeze and
// defrost sequencer. It steps the configuration through short timers,
// minima, maxima and random small values, and it stalls both streams at
// random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int LONG_HOLD_AT     = 600;
  localparam int LONG_HOLD_CYCLES = 200;

  localparam logic [2:0] DP_IDLE      = 3'd0;
  localparam logic [2:0] DP_WAIT_COLD = 3'd1;
  localparam logic [2:0] DP_COMPR_OFF = 3'd2;
  localparam logic [2:0] DP_HEAT_ON   = 3'd3;
  localparam logic [2:0] DP_HEATING   = 3'd4;
  localparam logic [2:0] DP_HEAT_OFF  = 3'd5;
  localparam logic [2:0] DP_RESTART   = 3'd6;

  localparam logic [2:0] FUNC_NOP5 = 3'd5;
  localparam logic [2:0] FUNC_NOP6 = 3'd6;
  localparam logic [2:0] FUNC_NOP7 = 3'd7;

  // flag bits in the order they sit in tdata [30:26]
  localparam logic [4:0] FL_NONE     = 5'b00000;
  localparam logic [4:0] FL_OVERHEAT = 5'b00001;
  localparam logic [4:0] FL_EVA_ERR  = 5'b00010;
  localparam logic [4:0] FL_CAB_ERR  = 5'b00100;
  localparam logic [4:0] FL_SF_SET   = 5'b01000;
  localparam logic [4:0] FL_DOS      = 5'b10000;

  typedef struct packed {
    logic [2:0]  func;
    logic [10:0] cabinet_temp;
    logic [10:0] evaporator_temp;
    logic [3:0]  setpoint_index;
    logic [4:0]  flags;
  } ctl_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;
  logic [2:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  fridge_thermostat_defrost_controller_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // controller model state
  logic [15:0] cfg_regs [8];
  logic        th_tick, th_comp, th_heat, th_sf;
  logic [2:0]  th_eighths, th_phase;
  logic [5:0]  th_secs;
  logic [15:0] th_lock, th_heat_secs, th_run_min, th_sf_left;

  ctl_item_t          stim_q[$];
  ftdc_pkg::result_t  outputs_due[$];
  int                 fail_count = 0;
  logic               calm = 1'b0;

  function automatic logic [31:0] reg_mask(input ftdc_pkg::reg_idx_e idx);
    int w;
    w = (idx <= ftdc_pkg::REG_OFF_OFFSET) ? ftdc_pkg::OFFS_W :
        (idx <= ftdc_pkg::REG_EVA_STOP_TEMP) ? ftdc_pkg::TEMP_W : ftdc_pkg::TIMER_W;
    return (32'd1 << w) - 32'd1;
  endfunction

  function automatic void compressor_stop();
    th_comp = 1'b0;
    th_lock = cfg_regs[ftdc_pkg::REG_LOCKOUT_SEC];
  endfunction

  function automatic ftdc_pkg::result_t thermostat_step(input ctl_item_t it);
    ftdc_pkg::result_t r;
    int      cab, eva, sp, on_t, off_t;
    logic    fault, dos, pulse;
    cab   = int'($signed(it.cabinet_temp));
    eva   = int'($signed(it.evaporator_temp));
    sp    = (it.setpoint_index >= 4'd8) ? -240 : -160 - 10 * int'(it.setpoint_index);
    on_t  = sp + int'($signed(cfg_regs[ftdc_pkg::REG_ON_OFFSET][ftdc_pkg::OFFS_W-1:0]));
    off_t = sp + int'($signed(cfg_regs[ftdc_pkg::REG_OFF_OFFSET][ftdc_pkg::OFFS_W-1:0]));
    fault = |(it.flags & (FL_OVERHEAT | FL_EVA_ERR | FL_CAB_ERR));
    dos   = |(it.flags & FL_DOS);
    pulse = 1'b0;
    if (|(it.flags & FL_SF_SET)) th_sf = 1'b1;
    case (it.func)
      ftdc_pkg::FUNC_INIT: begin
        th_lock    = (cab >= on_t) ? ftdc_pkg::SHORT_LOCKOUT_SECONDS
                                   : cfg_regs[ftdc_pkg::REG_LOCKOUT_SEC];
        th_comp    = 1'b0;
        th_tick    = 1'b0;
        th_heat    = 1'b0;
        th_phase   = dos ? DP_WAIT_COLD : DP_IDLE;
        th_run_min = '0;
        th_sf_left = ftdc_pkg::SUPERFREEZE_MINUTES;
        th_sf      = 1'b0;
      end
      ftdc_pkg::FUNC_TICK: th_tick = 1'b1;
      ftdc_pkg::FUNC_CONTROL: begin
        if (th_tick) begin
          th_tick = 1'b0;
          if (th_eighths == ftdc_pkg::EIGHTHS_LAST) begin
            th_eighths = '0;
            if (th_lock != 0) th_lock = th_lock - 16'd1;
            if (th_heat_secs != 0) th_heat_secs = th_heat_secs - 16'd1;
            if (th_secs == ftdc_pkg::SECONDS_LAST) begin
              th_secs = '0;
              // once a minute
              if (th_sf) begin
                th_sf_left = th_sf_left - 16'd1;
                if (th_sf_left == 0) begin
                  th_sf      = 1'b0;
                  th_sf_left = ftdc_pkg::SUPERFREEZE_MINUTES;
                end
              end
              if (th_comp && th_phase == DP_IDLE &&
                  th_run_min != ftdc_pkg::RUN_MINUTES_MAX)
                th_run_min = th_run_min + 16'd1;
              if (th_phase == DP_IDLE &&
                  th_run_min >= cfg_regs[ftdc_pkg::REG_INTERVAL_MIN])
                th_phase = DP_WAIT_COLD;
            end else begin
              th_secs = th_secs + 6'd1;
            end
          end else begin
            th_eighths = th_eighths + 3'd1;
          end
        end
        if (fault || th_phase > DP_WAIT_COLD) begin
          if (th_comp) compressor_stop();
        end else if (!th_comp) begin
          if ((th_sf || cab >= on_t) && th_lock == 0) th_comp = 1'b1;
        end else if (!th_sf && cab <= off_t) begin
          compressor_stop();
        end
      end
      ftdc_pkg::FUNC_DEFROST: begin
        if (fault) begin
          th_heat = 1'b0;
        end else begin
          case (th_phase)
            DP_IDLE: th_heat = 1'b0;
            DP_WAIT_COLD: begin
              if (eva <= int'($signed(
                    cfg_regs[ftdc_pkg::REG_EVA_START_TEMP][ftdc_pkg::TEMP_W-1:0])))
                th_phase = DP_COMPR_OFF;
              th_heat = 1'b0;
            end
            DP_COMPR_OFF: begin
              compressor_stop();
              th_phase = DP_HEAT_ON;
            end
            DP_HEAT_ON: begin
              th_heat      = 1'b1;
              th_heat_secs = cfg_regs[ftdc_pkg::REG_HEATER_MAX_SEC];
              th_phase     = DP_HEATING;
            end
            DP_HEATING: begin
              th_heat = 1'b1;
              if (eva >= int'($signed(
                    cfg_regs[ftdc_pkg::REG_EVA_STOP_TEMP][ftdc_pkg::TEMP_W-1:0])) ||
                  th_heat_secs == 0)
                th_phase = DP_HEAT_OFF;
            end
            DP_HEAT_OFF: begin
              th_heat = 1'b0;
              if (th_lock < cfg_regs[ftdc_pkg::REG_PASSIVE_SEC])
                th_lock = cfg_regs[ftdc_pkg::REG_PASSIVE_SEC];
              th_phase = DP_RESTART;
            end
            DP_RESTART: begin
              if (th_lock == 0) begin
                if (cab > off_t) th_comp = 1'b1;
                th_heat    = 1'b0;
                th_phase   = DP_IDLE;
                th_run_min = '0;
                pulse      = dos;
              end
            end
            default: ;
          endcase
        end
      end
      ftdc_pkg::FUNC_START: th_phase = DP_WAIT_COLD;
      default: ;
    endcase
    r.compressor_on      = th_comp;
    r.heater_on          = th_heat;
    r.defrost_phase      = th_phase;
    r.superfreeze_active = th_sf;
    r.defrost_flag_clear = pulse;
    return r;
  endfunction

  // input side: one item held until accepted, random gaps in between
  ctl_item_t item_on_bus;
  int        send_gap = 0;
  logic      send_bursty = 1'b1;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) outputs_due.push_back(thermostat_step(item_on_bus));
      if ($urandom_range(0, 63) == 0) send_bursty = !send_bursty;
      if (s_axis_tvalid_i && !s_axis_tready_o) begin
        // hold the item until it is taken
      end else if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid_i <= 1'b0;
      end else if (!calm && send_bursty && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(0, 6);
        s_axis_tvalid_i <= 1'b0;
      end else if (stim_q.size() != 0) begin
        item_on_bus = stim_q.pop_front();
        s_axis_tdata_i <= {1'b0, item_on_bus.flags, item_on_bus.setpoint_index,
                           item_on_bus.evaporator_temp, item_on_bus.cabinet_temp};
        s_axis_tuser_i <= item_on_bus.func;
        s_axis_tvalid_i <= 1'b1;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // output side: checks and back-pressure
  int   results_seen = 0;
  int   stall_left = 0;
  int   hold_left = 0;
  logic long_hold_done = 1'b0;
  logic recv_bursty = 1'b1;

  always @(posedge clk_i) begin : recv_side
    ftdc_pkg::result_t want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        results_seen++;
        if (outputs_due.size() == 0) begin
          $error("result 0x%02h arrived with nothing outstanding", m_axis_tdata_o);
          fail_count++;
        end else begin
          want = outputs_due.pop_front();
          if (m_axis_tdata_o[0] !== want.compressor_on) begin
            $error("compressor_on: expected %0d, got %0d", want.compressor_on,
                   m_axis_tdata_o[0]);
            fail_count++;
          end
          if (m_axis_tdata_o[1] !== want.heater_on) begin
            $error("heater_on: expected %0d, got %0d", want.heater_on, m_axis_tdata_o[1]);
            fail_count++;
          end
          if (m_axis_tdata_o[4:2] !== want.defrost_phase) begin
            $error("defrost_phase: expected %0d, got %0d", want.defrost_phase,
                   m_axis_tdata_o[4:2]);
            fail_count++;
          end
          if (m_axis_tdata_o[5] !== want.superfreeze_active) begin
            $error("superfreeze_active: expected %0d, got %0d", want.superfreeze_active,
                   m_axis_tdata_o[5]);
            fail_count++;
          end
          if (m_axis_tdata_o[6] !== want.defrost_flag_clear) begin
            $error("defrost_flag_clear: expected %0d, got %0d", want.defrost_flag_clear,
                   m_axis_tdata_o[6]);
            fail_count++;
          end
        end
      end
      // one long hold so the block backs up into its input
      if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD_CYCLES;
      end
      if ($urandom_range(0, 63) == 0) recv_bursty = !recv_bursty;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else if (!calm && recv_bursty && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 6);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || psel || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic cfg_read_check(input ftdc_pkg::reg_idx_e idx);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= 5'(4 * int'(idx));
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if ((prdata & reg_mask(idx)) != (32'(cfg_regs[idx]) & reg_mask(idx))) begin
      $error("register %0d: expected 0x%0h, got 0x%0h", idx,
             32'(cfg_regs[idx]) & reg_mask(idx), prdata & reg_mask(idx));
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_write(input ftdc_pkg::reg_idx_e idx, input int value);
    cfg_regs[idx] = 16'(value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(4 * int'(idx));
    pwdata  <= 32'(value) & reg_mask(idx);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_read_check(idx);
  endtask

  task automatic load_config(input int on_ofs, input int off_ofs, input int eva_start,
                             input int eva_stop, input int lockout, input int heat_max,
                             input int passive, input int interval);
    cfg_write(ftdc_pkg::REG_ON_OFFSET, on_ofs);
    cfg_write(ftdc_pkg::REG_OFF_OFFSET, off_ofs);
    cfg_write(ftdc_pkg::REG_EVA_START_TEMP, eva_start);
    cfg_write(ftdc_pkg::REG_EVA_STOP_TEMP, eva_stop);
    cfg_write(ftdc_pkg::REG_LOCKOUT_SEC, lockout);
    cfg_write(ftdc_pkg::REG_HEATER_MAX_SEC, heat_max);
    cfg_write(ftdc_pkg::REG_PASSIVE_SEC, passive);
    cfg_write(ftdc_pkg::REG_INTERVAL_MIN, interval);
  endtask

  task automatic push_item(input logic [2:0] f, input int cab, input int eva,
                           input int idx, input logic [4:0] flags);
    ctl_item_t it;
    it.func            = f;
    it.cabinet_temp    = 11'(cab);
    it.evaporator_temp = 11'(eva);
    it.setpoint_index  = 4'(idx);
    it.flags           = flags;
    stim_q.push_back(it);
  endtask

  // temperatures mostly near the setpoint band, now and then anywhere
  task automatic push_rand(input logic [2:0] f);
    ctl_item_t it;
    it.func = f;
    it.cabinet_temp = ($urandom_range(0, 9) == 0) ? 11'($urandom) :
                      11'(int'($urandom_range(0, 500)) - 400);
    if ($urandom_range(0, 3) == 0) it.evaporator_temp = 11'($urandom);
    else if ($urandom_range(0, 1) == 0) it.evaporator_temp = 11'(-int'($urandom_range(0, 1024)));
    else it.evaporator_temp = 11'($urandom_range(0, 1023));
    it.setpoint_index = 4'($urandom);
    it.flags = FL_NONE;
    if ($urandom_range(0, 29) == 0) it.flags |= FL_OVERHEAT;
    if ($urandom_range(0, 29) == 0) it.flags |= FL_EVA_ERR;
    if ($urandom_range(0, 29) == 0) it.flags |= FL_CAB_ERR;
    if ($urandom_range(0, 39) == 0) it.flags |= FL_SF_SET;
    if ($urandom_range(0, 1) == 0) it.flags |= FL_DOS;
    stim_q.push_back(it);
  endtask

  task automatic push_random(input int target);
    int n, k, steps;
    n = 0;
    while (n < target) begin
      k = $urandom_range(0, 99);
      if (k < 60) begin
        steps = $urandom_range(1, 40);
        repeat (steps) begin
          push_rand(ftdc_pkg::FUNC_TICK);
          push_rand(ftdc_pkg::FUNC_CONTROL);
        end
        n += 2 * steps;
      end else if (k < 85) begin
        // defrost walk with time still running
        if ($urandom_range(0, 9) < 3) begin
          push_rand(ftdc_pkg::FUNC_START);
          n++;
        end
        steps = $urandom_range(2, 10);
        repeat (steps) begin
          push_rand(ftdc_pkg::FUNC_DEFROST);
          push_rand(ftdc_pkg::FUNC_TICK);
          push_rand(ftdc_pkg::FUNC_CONTROL);
        end
        n += 3 * steps;
      end else if (k < 89) begin
        push_rand(ftdc_pkg::FUNC_INIT);
        n++;
      end else begin
        steps = $urandom_range(1, 4);
        repeat (steps) stim_q.push_back(ctl_item_t'(34'({$urandom, $urandom})));
        n += steps;
      end
    end
  endtask

  task automatic wait_idle();
    while (stim_q.size() != 0 || s_axis_tvalid_i || outputs_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    cfg_regs[ftdc_pkg::REG_ON_OFFSET]      = 16'(20);
    cfg_regs[ftdc_pkg::REG_OFF_OFFSET]     = 16'(-20);
    cfg_regs[ftdc_pkg::REG_EVA_START_TEMP] = 16'(-200);
    cfg_regs[ftdc_pkg::REG_EVA_STOP_TEMP]  = 16'(100);
    cfg_regs[ftdc_pkg::REG_LOCKOUT_SEC]    = 16'(300);
    cfg_regs[ftdc_pkg::REG_HEATER_MAX_SEC] = 16'(2400);
    cfg_regs[ftdc_pkg::REG_PASSIVE_SEC]    = 16'(600);
    cfg_regs[ftdc_pkg::REG_INTERVAL_MIN]   = 16'(480);
    th_tick = 1'b0;  th_comp = 1'b0;  th_heat = 1'b0;  th_sf = 1'b0;
    th_eighths = '0; th_phase = DP_IDLE; th_secs = '0;
    th_lock = '0; th_heat_secs = '0; th_run_min = '0;
    th_sf_left = ftdc_pkg::SUPERFREEZE_MINUTES;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < 8; i++) cfg_read_check(ftdc_pkg::reg_idx_e'(i));

    // short timers so the whole defrost cycle fits in a few items
    load_config(20, -20, -200, 100, 0, 1, 0, 1);
    @(negedge clk_i);
    push_item(ftdc_pkg::FUNC_INIT, 1023, 0, 0, FL_DOS | FL_SF_SET);
    push_item(ftdc_pkg::FUNC_INIT, -1024, 0, 15, FL_NONE);
    push_item(ftdc_pkg::FUNC_CONTROL, 1023, 0, 0, FL_NONE);
    push_item(ftdc_pkg::FUNC_CONTROL, -1024, 0, 15, FL_NONE);
    push_item(ftdc_pkg::FUNC_TICK, 0, 0, 9, FL_SF_SET);
    push_item(ftdc_pkg::FUNC_CONTROL, -1024, 0, 9, FL_NONE);
    push_item(ftdc_pkg::FUNC_CONTROL, -1024, 0, 9, FL_OVERHEAT);
    push_item(ftdc_pkg::FUNC_START, 0, 0, 0, FL_NONE);
    push_item(ftdc_pkg::FUNC_DEFROST, 0, 1023, 0, FL_NONE);
    push_item(ftdc_pkg::FUNC_DEFROST, 0, -1024, 0, FL_NONE);
    push_item(ftdc_pkg::FUNC_DEFROST, 0, -1024, 0, FL_EVA_ERR);
    push_item(ftdc_pkg::FUNC_DEFROST, 0, 0, 0, FL_NONE);
    push_item(ftdc_pkg::FUNC_DEFROST, 0, 0, 0, FL_NONE);
    push_item(ftdc_pkg::FUNC_DEFROST, 0, -1024, 0, FL_NONE);
    push_item(ftdc_pkg::FUNC_DEFROST, 0, 1023, 0, FL_NONE);
    push_item(ftdc_pkg::FUNC_DEFROST, 0, 0, 0, FL_CAB_ERR);
    push_item(ftdc_pkg::FUNC_DEFROST, 0, 0, 0, FL_NONE);
    push_item(ftdc_pkg::FUNC_DEFROST, 1023, 0, 0, FL_DOS);
    push_item(FUNC_NOP5, 1023, 1023, 15, FL_SF_SET);
    push_item(FUNC_NOP6, -1024, -1024, 0, FL_OVERHEAT | FL_EVA_ERR | FL_CAB_ERR);
    push_item(FUNC_NOP7, 1023, 1023, 15, ~FL_NONE);
    push_item(ftdc_pkg::FUNC_CONTROL, -1024, 0, 0, FL_NONE);
    push_item(ftdc_pkg::FUNC_INIT, -1024, 0, 15, FL_SF_SET);
    wait_idle();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: load_config(-200, -200, -1000, -1000, 0, 0, 0, 0);
        1: load_config(200, 200, 1000, 1000, 65535, 65535, 65535, 65535);
        default: load_config($urandom_range(0, 200), -int'($urandom_range(0, 200)),
                             -int'($urandom_range(0, 1000)), $urandom_range(0, 1000),
                             $urandom_range(0, 4), $urandom_range(0, 6),
                             $urandom_range(0, 4), $urandom_range(0, 2));
      endcase
      if (p == 4) calm <= 1'b1;
      @(negedge clk_i);
      push_random((p == 1) ? 200 : (p == 4) ? 380 : (p == 0) ? 350 : 400);
      wait_idle();
    end

    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && outputs_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[fridge_thermostat_defrost_controller_core.f]
rtl/core/ftdc_pkg.sv
rtl/core/ftdc_regs.sv
rtl/core/ftdc_ctrl.sv
rtl/core/fridge_thermostat_defrost_controller_core.sv
tb/testbench.sv
